[hdl/crld_pkg.sv]
// Shared types, constants and codes of the cluster run list decoder.
`default_nettype none

package crld_pkg;

    localparam int unsigned MAX_FIELD_BYTES = 8;

    localparam int unsigned CLUSTER_W = 48;
    localparam int unsigned WIDE_W    = 64;
    localparam int unsigned POS_W     = 16;
    localparam int unsigned STATUS_W  = 3;
    localparam int unsigned CFG_IDX_W = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_SIZE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_VCN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_LAST  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AREA_LENGTH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARSE_MODE    = 3'd4;

    // End-of-list status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OVERRUN   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_LEN   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_MISMATCH  = 3'd4;

    // Result kinds.
    localparam logic KIND_RUN    = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic [CLUSTER_W-1:0] volume_clusters;
        logic [CLUSTER_W-1:0] first_virtual_cluster;
        logic [CLUSTER_W-1:0] expected_last_virtual_cluster;
        logic [POS_W-1:0]     area_length;
        logic                 sparse_mode;
    } crld_cfg_t;

    typedef struct packed {
        logic                 kind;
        logic [CLUSTER_W-1:0] run_start_cluster;
        logic [WIDE_W-1:0]    run_length;
        logic                 run_is_hole;
        logic [STATUS_W-1:0]  status;
        logic [WIDE_W-1:0]    allocated_clusters;
        logic [POS_W-1:0]     bytes_used;
    } crld_result_t;

endpackage

`default_nettype wire

[hdl/crld_cfg_regs.sv]
// Configuration register file of the cluster run list decoder.
`default_nettype none

module crld_cfg_regs
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [crld_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [crld_pkg::CLUSTER_W-1:0] cfg_data,
    output crld_pkg::crld_cfg_t                 cfg
);
    import crld_pkg::*;

    crld_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_VOLUME_SIZE:    cfg_reg.volume_clusters <= cfg_data;
                CFG_FIRST_VCN:      cfg_reg.first_virtual_cluster <= cfg_data;
                CFG_EXPECTED_LAST:  cfg_reg.expected_last_virtual_cluster <= cfg_data;
                CFG_AREA_LENGTH:    cfg_reg.area_length <= cfg_data[POS_W-1:0];
                CFG_SPARSE_MODE:    cfg_reg.sparse_mode <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[hdl/crld_core.sv]
// Input byte register and run list decode state of the cluster run list decoder.
`default_nettype none

module crld_core
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [7:0]           list_byte,
    input  wire crld_pkg::crld_cfg_t  cfg,
    output logic                      res_valid,
    input  wire logic                 res_ready,
    output crld_pkg::crld_result_t    res
);
    import crld_pkg::*;

    localparam logic [1:0] PH_HDR = 2'd0;
    localparam logic [1:0] PH_CNT = 2'd1;
    localparam logic [1:0] PH_DLT = 2'd2;

    logic [7:0]        byte_reg;
    logic              byte_valid_reg;

    logic [1:0]        phase_reg,       phase_next;
    logic [3:0]        cnt_left_reg,    cnt_left_next;
    logic [3:0]        dlt_left_reg,    dlt_left_next;
    logic [2:0]        idx_reg,         idx_next;
    logic [WIDE_W-1:0] cnt_acc_reg,     cnt_acc_next;
    logic [WIDE_W-1:0] dlt_acc_reg,     dlt_acc_next;
    logic [WIDE_W-1:0] cur_reg,         cur_next;
    logic [WIDE_W-1:0] nvc_reg,         nvc_next;
    logic [WIDE_W-1:0] alloc_reg,       alloc_next;
    logic [POS_W-1:0]  pos_reg,         pos_next;

    logic              has_result;
    logic              advance;

    logic [3:0]        cl;
    logic [3:0]        ol;
    logic [WIDE_W-1:0] nvc_eff;
    logic [POS_W+1:0]  run_end;
    logic [WIDE_W-1:0] byte_shifted;
    logic [WIDE_W-1:0] cnt_new;
    logic [WIDE_W-1:0] dlt_new;
    logic [WIDE_W-1:0] cur_new;
    logic [WIDE_W:0]   run_top;
    logic [3:0]        cnt_left_dec;
    logic [3:0]        dlt_left_dec;
    logic              do_restart;

    assign cl           = byte_reg[3:0];
    assign ol           = byte_reg[7:4];
    assign nvc_eff      = (pos_reg == '0)
                          ? {{(WIDE_W-CLUSTER_W){1'b0}}, cfg.first_virtual_cluster}
                          : nvc_reg;
    assign run_end      = {2'b00, pos_reg} + 18'd1 + {14'd0, cl} + {14'd0, ol};
    assign byte_shifted = {{(WIDE_W-8){1'b0}}, byte_reg} << {idx_reg, 3'b000};
    assign cnt_new      = cnt_acc_reg | byte_shifted;
    assign cnt_left_dec = cnt_left_reg - 4'd1;
    assign dlt_left_dec = dlt_left_reg - 4'd1;

    // The last offset byte carries the sign of the whole delta.
    always_comb
    begin
        dlt_new = dlt_acc_reg | byte_shifted;
        if (byte_reg[7] && (idx_reg != 3'd7) && (dlt_left_dec == 4'd0))
        begin
            dlt_new = dlt_new | ({WIDE_W{1'b1}} << {idx_reg + 3'd1, 3'b000});
        end
    end

    assign cur_new = cur_reg + dlt_new;
    assign run_top = {1'b0, cur_new} + {1'b0, cnt_acc_reg};

    always_comb
    begin
        phase_next    = phase_reg;
        cnt_left_next = cnt_left_reg;
        dlt_left_next = dlt_left_reg;
        idx_next      = idx_reg;
        cnt_acc_next  = cnt_acc_reg;
        dlt_acc_next  = dlt_acc_reg;
        cur_next      = cur_reg;
        nvc_next      = nvc_reg;
        alloc_next    = alloc_reg;
        pos_next      = pos_reg;
        has_result    = 1'b0;
        do_restart    = 1'b0;
        res           = '0;
        res.bytes_used         = pos_reg + 16'd1;
        res.allocated_clusters = alloc_reg;

        unique case (phase_reg)
            PH_CNT:
            begin
                cnt_acc_next  = cnt_new;
                idx_next      = idx_reg + 3'd1;
                pos_next      = pos_reg + 16'd1;
                cnt_left_next = cnt_left_dec;
                if (cnt_left_dec == 4'd0)
                begin
                    idx_next = 3'd0;
                    if (dlt_left_reg == 4'd0)
                    begin
                        // Hole: no offset field, nothing allocated, no volume check.
                        phase_next            = PH_HDR;
                        nvc_next              = nvc_reg + cnt_new;
                        has_result            = 1'b1;
                        res                   = '0;
                        res.kind              = KIND_RUN;
                        res.run_length        = cnt_new;
                        res.run_is_hole       = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_DLT;
                    end
                end
            end
            PH_DLT:
            begin
                dlt_acc_next  = dlt_new;
                idx_next      = idx_reg + 3'd1;
                pos_next      = pos_reg + 16'd1;
                dlt_left_next = dlt_left_dec;
                if (dlt_left_dec == 4'd0)
                begin
                    phase_next = PH_HDR;
                    idx_next   = 3'd0;
                    nvc_next   = nvc_reg + cnt_acc_reg;
                    cur_next   = cur_new;
                    alloc_next = alloc_reg + cnt_acc_reg;
                    has_result = 1'b1;
                    if ((cur_new < {{(WIDE_W-CLUSTER_W){1'b0}}, cfg.volume_clusters}) &&
                        (run_top <= {{(WIDE_W+1-CLUSTER_W){1'b0}}, cfg.volume_clusters}))
                    begin
                        res                   = '0;
                        res.kind              = KIND_RUN;
                        res.run_start_cluster = cur_new[CLUSTER_W-1:0];
                        res.run_length        = cnt_acc_reg;
                    end
                    else
                    begin
                        // The failing run's count is already part of the total.
                        do_restart             = 1'b1;
                        res.kind               = KIND_STATUS;
                        res.status             = ST_OUTSIDE;
                        res.allocated_clusters = alloc_reg + cnt_acc_reg;
                    end
                end
            end
            default:
            begin
                // Header byte; an unused phase code behaves like a header.
                has_result = 1'b1;
                res.kind   = KIND_STATUS;
                if (pos_reg >= cfg.area_length)
                begin
                    do_restart = 1'b1;
                    res.status = ST_OVERRUN;
                end
                else if ((cl == 4'd0) && (ol == 4'd0))
                begin
                    do_restart = 1'b1;
                    res.status = ((nvc_eff - 64'd1) ==
                                  {{(WIDE_W-CLUSTER_W){1'b0}},
                                   cfg.expected_last_virtual_cluster})
                                 ? ST_OK : ST_MISMATCH;
                end
                else if ((cl == 4'd0) || (cl > 4'(MAX_FIELD_BYTES)) ||
                         (ol > 4'(MAX_FIELD_BYTES)) ||
                         ((ol == 4'd0) && !cfg.sparse_mode))
                begin
                    do_restart = 1'b1;
                    res.status = ST_BAD_LEN;
                end
                else if (run_end >= {2'b00, cfg.area_length})
                begin
                    do_restart = 1'b1;
                    res.status = ST_OVERRUN;
                end
                else
                begin
                    has_result    = 1'b0;
                    res           = '0;
                    phase_next    = PH_CNT;
                    cnt_left_next = cl;
                    dlt_left_next = ol;
                    idx_next      = 3'd0;
                    cnt_acc_next  = '0;
                    dlt_acc_next  = '0;
                    nvc_next      = nvc_eff;
                    pos_next      = pos_reg + 16'd1;
                end
            end
        endcase

        if (do_restart)
        begin
            phase_next    = PH_HDR;
            cnt_left_next = 4'd0;
            dlt_left_next = 4'd0;
            idx_next      = 3'd0;
            cnt_acc_next  = '0;
            dlt_acc_next  = '0;
            cur_next      = '0;
            nvc_next      = {{(WIDE_W-CLUSTER_W){1'b0}}, cfg.first_virtual_cluster};
            alloc_next    = '0;
            pos_next      = '0;
        end
    end

    // A byte that yields no result moves on even while the result side is stalled.
    assign advance   = byte_valid_reg && (!has_result || res_ready);
    assign in_ready  = !byte_valid_reg || advance;
    assign res_valid = byte_valid_reg && has_result;

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= list_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
            phase_reg      <= PH_HDR;
            cnt_left_reg   <= 4'd0;
            dlt_left_reg   <= 4'd0;
            idx_reg        <= 3'd0;
            cnt_acc_reg    <= '0;
            dlt_acc_reg    <= '0;
            cur_reg        <= '0;
            nvc_reg        <= '0;
            alloc_reg      <= '0;
            pos_reg        <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                byte_valid_reg <= in_valid;
            end
            if (advance)
            begin
                phase_reg    <= phase_next;
                cnt_left_reg <= cnt_left_next;
                dlt_left_reg <= dlt_left_next;
                idx_reg      <= idx_next;
                cnt_acc_reg  <= cnt_acc_next;
                dlt_acc_reg  <= dlt_acc_next;
                cur_reg      <= cur_next;
                nvc_reg      <= nvc_next;
                alloc_reg    <= alloc_next;
                pos_reg      <= pos_next;
            end
        end
    end

endmodule

`default_nettype wire

[hdl/crld_out_reg.sv]
// Result register of the cluster run list decoder.
`default_nettype none

module crld_out_reg
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              res_valid,
    output logic                                   res_ready,
    input  wire crld_pkg::crld_result_t            res,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output crld_pkg::crld_result_t                 out_res
);
    import crld_pkg::*;

    logic         valid_reg;
    crld_result_t res_reg;

    assign res_ready = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            res_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            valid_reg <= res_valid;
        end
    end

endmodule

`default_nettype wire

[hdl/cluster_run_list_decoder.sv]
// Top level of the cluster run list decoder.
`default_nettype none

// The decoder takes a cluster run list one byte per transaction and returns one
// transaction per decoded run and one status transaction at the end of each
// list. A header byte gives the count field length in its low nibble and the
// offset field length in its high nibble; the count is little-endian and the
// offset is a sign-extended delta added to the running volume cluster. A zero
// header, or any error, closes the list with a status (0 ok, 1 overruns area,
// 2 bad field length, 3 outside volume, 4 last cluster mismatch), and the next
// byte starts a fresh list. In sparse mode a run without an offset field is a
// hole: start cluster 0, not counted as allocated, not checked against the
// volume. The block takes one byte every cycle while its results are taken. Each
// byte passes an input register, then one step of decode logic whose longest
// path is the offset add followed by the volume bound compare, then a result
// register, from which the result is presented on the outputs. Bytes that
// yield no result keep flowing while the result register waits on the consumer.
// Configuration is written through the cfg channel, which is always ready; the
// user writes it only while the block is idle; the block does not enforce it.
module cluster_run_list_decoder
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [crld_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [crld_pkg::CLUSTER_W-1:0] cfg_data,

    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [7:0]                     list_byte,

    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic                                kind,
    output logic [crld_pkg::CLUSTER_W-1:0]      run_start_cluster,
    output logic [crld_pkg::WIDE_W-1:0]         run_length,
    output logic                                run_is_hole,
    output logic [crld_pkg::STATUS_W-1:0]       status,
    output logic [crld_pkg::WIDE_W-1:0]         allocated_clusters,
    output logic [crld_pkg::POS_W-1:0]          bytes_used
);
    import crld_pkg::*;

    crld_cfg_t    cfg;
    crld_result_t core_res;
    crld_result_t out_res;
    logic         core_res_valid;
    logic         core_res_ready;

    // Register file for the five configuration registers.
    crld_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Input byte register plus the run list state machine.
    crld_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .list_byte (list_byte),
        .cfg       (cfg),
        .res_valid (core_res_valid),
        .res_ready (core_res_ready),
        .res       (core_res)
    );

    // Result register that holds a finished transaction for the consumer.
    crld_out_reg u_out_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (core_res_valid),
        .res_ready (core_res_ready),
        .res       (core_res),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign kind               = out_res.kind;
    assign run_start_cluster  = out_res.run_start_cluster;
    assign run_length         = out_res.run_length;
    assign run_is_hole        = out_res.run_is_hole;
    assign status             = out_res.status;
    assign allocated_clusters = out_res.allocated_clusters;
    assign bytes_used         = out_res.bytes_used;

endmodule

`default_nettype wire

[sim/crld_checker.sv]
// Checker that predicts and compares every result of the cluster run list decoder.
`timescale 1ns / 100ps

module crld_checker
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           cfg_valid,
    input  wire logic                           cfg_ready,
    input  wire logic [crld_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [crld_pkg::CLUSTER_W-1:0] cfg_data,

    input  wire logic                           in_valid,
    input  wire logic                           in_ready,
    input  wire logic [7:0]                     list_byte,

    input  wire logic                           out_valid,
    input  wire logic                           out_ready,
    input  wire logic                           kind,
    input  wire logic [crld_pkg::CLUSTER_W-1:0] run_start_cluster,
    input  wire logic [crld_pkg::WIDE_W-1:0]    run_length,
    input  wire logic                           run_is_hole,
    input  wire logic [crld_pkg::STATUS_W-1:0]  status,
    input  wire logic [crld_pkg::WIDE_W-1:0]    allocated_clusters,
    input  wire logic [crld_pkg::POS_W-1:0]     bytes_used,

    output int                                  error_count,
    output int                                  pending_results,
    output logic                                list_open
);

    import crld_pkg::*;

    typedef enum logic [1:0] {AWAIT_HEADER, COUNT_FIELD, OFFSET_FIELD} walk_phase_t;

    // Register copies.
    logic [CLUSTER_W-1:0] vol_total;
    logic [CLUSTER_W-1:0] list_first_vcn;
    logic [CLUSTER_W-1:0] list_end_vcn;
    logic [POS_W-1:0]     area_limit;
    logic                 sparse_on;

    // Decoder state.
    walk_phase_t          walk;
    logic [3:0]           count_left;
    logic [3:0]           offset_left;
    logic [2:0]           field_idx;
    logic [WIDE_W-1:0]    count_acc;
    logic [WIDE_W-1:0]    offset_acc;
    logic [WIDE_W-1:0]    cluster_now;
    logic [WIDE_W-1:0]    vcn_next;
    logic [WIDE_W-1:0]    allocated;
    logic [POS_W-1:0]     position;

    crld_result_t         expected_results [$];
    int                   errors;

    function automatic void restart_list();
        walk        = AWAIT_HEADER;
        count_left  = '0;
        offset_left = '0;
        field_idx   = '0;
        count_acc   = '0;
        offset_acc  = '0;
        cluster_now = '0;
        vcn_next    = {16'd0, list_first_vcn};
        allocated   = '0;
        position    = '0;
    endfunction

    // Closes the list; position still names the byte being taken.
    function automatic bit report_status(input logic [STATUS_W-1:0] code,
                                         output crld_result_t res);
        res                    = '0;
        res.kind               = KIND_STATUS;
        res.status             = code;
        res.allocated_clusters = allocated;
        res.bytes_used         = position + 16'd1;
        restart_list();
        return 1'b1;
    endfunction

    // Called after the last byte of a run, with position already advanced.
    function automatic bit close_run(input bit hole, output crld_result_t res);
        logic [WIDE_W-1:0] clusters;
        logic [WIDE_W-1:0] bound;
        res       = '0;
        clusters  = count_acc;
        bound     = {16'd0, vol_total};
        walk      = AWAIT_HEADER;
        field_idx = '0;
        vcn_next  = vcn_next + clusters;
        if (!hole)
        begin
            cluster_now = cluster_now + offset_acc;
            allocated   = allocated + clusters;
            if (!(cluster_now < bound && clusters <= bound - cluster_now))
            begin
                position = position - 16'd1;
                return report_status(ST_OUTSIDE, res);
            end
        end
        res.kind              = KIND_RUN;
        res.run_start_cluster = hole ? '0 : cluster_now[CLUSTER_W-1:0];
        res.run_length        = clusters;
        res.run_is_hole       = hole;
        return 1'b1;
    endfunction

    function automatic bit decode_byte(input logic [7:0] b, output crld_result_t res);
        logic [3:0] cnt_bytes;
        logic [3:0] ofs_bytes;
        logic [2:0] idx;
        res       = '0;
        cnt_bytes = b[3:0];
        ofs_bytes = b[7:4];
        case (walk)
            COUNT_FIELD:
            begin
                count_acc  = count_acc | ({56'd0, b} << (8 * field_idx));
                field_idx  = field_idx + 3'd1;
                position   = position + 16'd1;
                count_left = count_left - 4'd1;
                if (count_left != 0)
                    return 1'b0;
                if (offset_left == 0)
                    return close_run(1'b1, res);
                walk      = OFFSET_FIELD;
                field_idx = '0;
                return 1'b0;
            end
            OFFSET_FIELD:
            begin
                idx         = field_idx;
                offset_acc  = offset_acc | ({56'd0, b} << (8 * idx));
                field_idx   = field_idx + 3'd1;
                position    = position + 16'd1;
                offset_left = offset_left - 4'd1;
                if (offset_left != 0)
                    return 1'b0;
                // The top byte of the offset carries the sign.
                if (b[7] && idx < 3'd7)
                    offset_acc = offset_acc | ({WIDE_W{1'b1}} << (8 * (idx + 1)));
                return close_run(1'b0, res);
            end
            default:
            begin
                if (position == 0)
                    vcn_next = {16'd0, list_first_vcn};
                if (position >= area_limit)
                    return report_status(ST_OVERRUN, res);
                if (b == 8'h00)
                    return report_status((vcn_next - 64'd1) == {16'd0, list_end_vcn}
                                         ? ST_OK : ST_MISMATCH, res);
                if (cnt_bytes == 0 || cnt_bytes > MAX_FIELD_BYTES
                    || ofs_bytes > MAX_FIELD_BYTES || (ofs_bytes == 0 && !sparse_on))
                    return report_status(ST_BAD_LEN, res);
                if (32'(position) + 32'd1 + 32'(cnt_bytes) + 32'(ofs_bytes)
                    >= 32'(area_limit))
                    return report_status(ST_OVERRUN, res);
                walk        = COUNT_FIELD;
                count_left  = cnt_bytes;
                offset_left = ofs_bytes;
                field_idx   = '0;
                count_acc   = '0;
                offset_acc  = '0;
                position    = position + 16'd1;
                return 1'b0;
            end
        endcase
    endfunction

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        crld_result_t seen;
        crld_result_t want;
        crld_result_t fresh;
        if (!rst_n)
        begin
            vol_total      = '0;
            list_first_vcn = '0;
            list_end_vcn   = '0;
            area_limit     = '0;
            sparse_on      = 1'b0;
            restart_list();
            expected_results.delete();
            errors = 0;
            error_count     <= 0;
            pending_results <= 0;
            list_open       <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                seen = {kind, run_start_cluster, run_length, run_is_hole, status,
                        allocated_clusters, bytes_used};
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t ns: unexpected result, expected none, actual %h",
                             $time, seen);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("kind", 64'(want.kind), 64'(seen.kind));
                    check_field("run_start_cluster", 64'(want.run_start_cluster),
                                64'(seen.run_start_cluster));
                    check_field("run_length", want.run_length, seen.run_length);
                    check_field("run_is_hole", 64'(want.run_is_hole), 64'(seen.run_is_hole));
                    check_field("status", 64'(want.status), 64'(seen.status));
                    check_field("allocated_clusters", want.allocated_clusters,
                                seen.allocated_clusters);
                    check_field("bytes_used", 64'(want.bytes_used), 64'(seen.bytes_used));
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_VOLUME_SIZE:    vol_total      = cfg_data;
                    CFG_FIRST_VCN:      list_first_vcn = cfg_data;
                    CFG_EXPECTED_LAST:  list_end_vcn   = cfg_data;
                    CFG_AREA_LENGTH:    area_limit     = cfg_data[POS_W-1:0];
                    CFG_SPARSE_MODE:    sparse_on      = cfg_data[0];
                    default: ;
                endcase
            end

            if (in_valid && in_ready)
            begin
                if (decode_byte(list_byte, fresh))
                    expected_results.push_back(fresh);
            end

            error_count     <= errors;
            pending_results <= expected_results.size();
            list_open       <= (walk != AWAIT_HEADER) || (position != 0);
        end
    end

endmodule

[sim/testbench.sv]
// Top of the decoder regression: clock, reset, stimulus, consumer stalls and verdict.
`timescale 1ns / 100ps

module testbench;

    import crld_pkg::*;

    localparam logic [CLUSTER_W-1:0] CLUSTER_MAX = '1;
    localparam logic [POS_W-1:0]     AREA_MAX    = '1;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;

    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CLUSTER_W-1:0]   cfg_data  = '0;

    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    logic [7:0]             list_byte = '0;

    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic                   kind;
    logic [CLUSTER_W-1:0]   run_start_cluster;
    logic [WIDE_W-1:0]      run_length;
    logic                   run_is_hole;
    logic [STATUS_W-1:0]    status;
    logic [WIDE_W-1:0]      allocated_clusters;
    logic [POS_W-1:0]       bytes_used;

    int                     error_count;
    int                     pending_results;
    logic                   list_open;

    // Raised by the stimulus to ask the consumer for one long hold-off.
    logic                   hold_off  = 1'b0;

    // Register values as last written; the list composer aims its lists at them.
    logic [CLUSTER_W-1:0]   vol_clusters;
    logic [CLUSTER_W-1:0]   first_vcn;
    logic [CLUSTER_W-1:0]   closing_vcn;
    logic [POS_W-1:0]       list_area;
    logic                   holes_allowed;

    logic [7:0]             list_image [$];
    int                     bytes_sent = 0;
    int                     burst_left = 0;

    cluster_run_list_decoder DUT (.*);

    crld_checker scoreboard (.*);

    always #5 clk = ~clk;

    // The run is cut off if it hangs anywhere, including while waiting for results.
    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [63:0] wide_random();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [CLUSTER_W-1:0] rand_cluster();
        return {16'($urandom), $urandom};
    endfunction

    // Fewest little-endian bytes that hold an unsigned count (at least one).
    function automatic int unsigned_span(input logic [63:0] v);
        int n;
        n = 1;
        while (n < 8 && (v >> (8 * n)) != 0)
            n++;
        return n;
    endfunction

    // Fewest bytes whose sign extension gives back the offset.
    function automatic int signed_span(input logic [63:0] v);
        int n;
        logic [63:0] ext;
        n = 1;
        while (n < 8)
        begin
            ext = $signed(v << (64 - 8 * n)) >>> (64 - 8 * n);
            if (ext == v)
                break;
            n++;
        end
        return n;
    endfunction

    // Offers one byte and returns at the edge where it is taken. The sender works
    // in bursts; between bursts valid drops for a random gap, and some bursts are
    // long with no gap at all.
    task automatic offer_byte(input logic [7:0] value);
        int pause;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(24, 60)
                                                     : $urandom_range(1, 10);
            pause = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (pause != 0)
            begin
                in_valid <= 1'b0;
                repeat (pause) @(posedge clk);
            end
        end
        burst_left--;
        in_valid  <= 1'b1;
        list_byte <= value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CLUSTER_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Writes every register; only called while the decoder is idle.
    task automatic load_config(input logic [CLUSTER_W-1:0] clusters,
                               input logic [CLUSTER_W-1:0] start_vcn,
                               input logic [CLUSTER_W-1:0] end_vcn,
                               input logic [POS_W-1:0] area,
                               input logic sparse);
        vol_clusters  = clusters;
        first_vcn     = start_vcn;
        closing_vcn   = end_vcn;
        list_area     = area;
        holes_allowed = sparse;
        write_reg(CFG_VOLUME_SIZE, clusters);
        write_reg(CFG_FIRST_VCN, start_vcn);
        write_reg(CFG_EXPECTED_LAST, end_vcn);
        write_reg(CFG_AREA_LENGTH, {32'd0, area});
        write_reg(CFG_SPARSE_MODE, {47'd0, sparse});
        cfg_valid <= 1'b0;
    endtask

    // Builds one run list into list_image. Runs mostly land inside the volume and
    // the list fits the area; half the lists have counts that add up to the
    // declared last cluster. Some runs jump outside the volume, some counts are
    // wide, and an occasional list ignores the area to provoke an overrun.
    task automatic compose_list();
        logic [63:0] target;
        logic [63:0] remaining;
        logic [63:0] clusters;
        logic [63:0] start;
        logic [63:0] delta;
        logic [63:0] cursor;
        logic [63:0] span;
        logic [63:0] bound;
        int runs;
        int pos;
        int cnt_bytes;
        int ofs_bytes;
        bit aim_end;
        bit hole;
        bit reckless;
        list_image.delete();
        aim_end   = ($urandom_range(0, 1) == 1);
        reckless  = ($urandom_range(0, 7) == 0);
        runs      = $urandom_range(0, 6);
        bound     = {16'd0, vol_clusters};
        target    = {16'd0, closing_vcn} + 64'd1 - {16'd0, first_vcn};
        remaining = target;
        cursor    = '0;
        pos       = 0;
        for (int r = 0; r < runs; r++)
        begin
            hole = holes_allowed && ($urandom_range(0, 3) == 0);
            if (aim_end)
                clusters = (r == runs - 1) ? remaining : remaining >> $urandom_range(1, 4);
            else if ($urandom_range(0, 3) == 0)
                clusters = wide_random() >> $urandom_range(0, 63);
            else
                clusters = 64'($urandom_range(0, 300));
            remaining = remaining - clusters;

            cnt_bytes = unsigned_span(clusters);
            if ($urandom_range(0, 3) == 0)
                cnt_bytes = $urandom_range(cnt_bytes, 8);

            ofs_bytes = 0;
            delta     = '0;
            if (!hole)
            begin
                if (vol_clusters != 0 && clusters <= bound && $urandom_range(0, 7) != 0)
                begin
                    span  = (clusters == 0) ? bound : bound - clusters + 64'd1;
                    start = wide_random() % span;
                end
                else
                    start = {16'd0, rand_cluster()};
                delta     = start - cursor;
                cursor    = start;
                ofs_bytes = signed_span(delta);
                if ($urandom_range(0, 3) == 0)
                    ofs_bytes = $urandom_range(ofs_bytes, 8);
            end

            // The next header has to lie inside the area.
            if (!reckless && pos + 1 + cnt_bytes + ofs_bytes >= int'(list_area))
                break;

            list_image.push_back({ofs_bytes[3:0], cnt_bytes[3:0]});
            for (int i = 0; i < cnt_bytes; i++)
                list_image.push_back(clusters[8 * i +: 8]);
            for (int i = 0; i < ofs_bytes; i++)
                list_image.push_back(delta[8 * i +: 8]);
            pos += 1 + cnt_bytes + ofs_bytes;
        end
        list_image.push_back(8'h00);
    endtask

    // Feeds zero bytes until the decoder is back at the start of a list. A zero
    // byte always closes a list when it lands on a header.
    task automatic close_open_list();
        in_valid <= 1'b0;
        @(posedge clk);
        while (list_open)
        begin
            offer_byte(8'h00);
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Stops the sender until every expected result has come back, then lets the
    // two pipeline stages empty out so the registers may be rewritten.
    task automatic drain();
        close_open_list();
        while (pending_results != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // Mostly whole lists with random content; the rest is random bytes that break
    // lists at arbitrary points.
    task automatic run_phase(input int budget);
        int origin;
        origin = bytes_sent;
        while (bytes_sent - origin < budget)
        begin
            if ($urandom_range(0, 4) != 0)
            begin
                compose_list();
                foreach (list_image[i])
                    offer_byte(list_image[i]);
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    offer_byte(8'($urandom_range(0, 255)));
            end
            close_open_list();
        end
        drain();
    endtask

    // Consumer. It switches at random among four stall patterns: always ready,
    // coin flip, mostly stalled, or mostly ready. Once per request from the
    // stimulus it holds off for a long stretch so the decoder backs up.
    initial
    begin : consumer
        int style;
        int span;
        bit held;
        style = 0;
        span  = 0;
        held  = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off && !held)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            if (!hold_off)
                held = 1'b0;
            if (span == 0)
            begin
                style = $urandom_range(0, 3);
                span  = $urandom_range(16, 96);
            end
            span--;
            case (style)
                0:       out_ready <= 1'b1;
                1:       out_ready <= ($urandom_range(0, 1) == 1);
                2:       out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    initial
    begin : stimulus
        logic [7:0] opening [$];
        logic [CLUSTER_W-1:0] base;
        int unsigned k;

        // Directed lists under a 12-byte area, sparse mode on, volume of 1000:
        // a run ending on the declared last cluster; a hole then a run whose
        // negative offset falls below the volume; count lengths of 9 and 0 and
        // an offset length of 9; a header that does not fit the area; and a
        // hole of maximum length whose wrapped total misses the last cluster.
        opening = '{8'h11, 8'h05, 8'h0A, 8'h00,
                    8'h01, 8'hFF, 8'h21, 8'h03, 8'hF6, 8'hFF,
                    8'h09, 8'h91, 8'h30, 8'h88,
                    8'h08, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Reset registers leave an empty area, so the first header overruns it.
        offer_byte(8'h00);
        drain();

        load_config(48'd1000, 48'd100, 48'd104, 16'd12, 1'b1);
        foreach (opening[i])
            offer_byte(opening[i]);
        drain();

        // Largest volume and area, lists starting at cluster zero.
        load_config(CLUSTER_MAX, '0, 48'($urandom_range(0, 4000)), AREA_MAX, 1'b1);
        run_phase(150);

        // Empty volume: only holes get through.
        base = rand_cluster();
        load_config('0, base, base + 48'($urandom_range(0, 4000)),
                    16'($urandom_range(64, 400)), 1'b1);
        run_phase(70);

        // Lists starting at the top cluster number so the end check wraps;
        // sparse mode off makes a missing offset a bad length.
        k = $urandom_range(1, 4000);
        load_config(rand_cluster() | 48'd1, CLUSTER_MAX, 48'(k - 1),
                    16'($urandom_range(100, 2000)), 1'b0);
        run_phase(100);

        // Tiny volume and area, last cluster at its maximum.
        k = $urandom_range(0, 4000);
        load_config(48'($urandom_range(1, 5000)), CLUSTER_MAX - 48'(k), CLUSTER_MAX,
                    16'($urandom_range(20, 60)), 1'b1);
        run_phase(90);

        // Zero area: every byte is an overrun.
        load_config(rand_cluster(), '0, '0, '0, 1'b0);
        run_phase(30);

        // Back pressure: the consumer stops for a long stretch while bytes keep
        // coming, so the result register fills and the input stalls.
        base = rand_cluster();
        load_config(CLUSTER_MAX, base, base + 48'($urandom_range(0, 4000)), AREA_MAX, 1'b1);
        hold_off <= 1'b1;
        run_phase(150);
        hold_off <= 1'b0;

        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
